@@ rtl/ssk_pkg.sv @@
// ----------------------------------------------------------------------------
// ssk_pkg: shared types and constants of the steady-state estimator step
// Opcodes, matrix codes, register indexes, sequencer states and the control
// and status groups that pass between the sequencer and the serial MAC.
// ----------------------------------------------------------------------------
package ssk_pkg;

    localparam int DIM = 8;             // rows/columns held in the store

    typedef enum logic [1:0] {
        OP_COEF   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_STATE  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MAT_A  = 2'd0,
        MAT_BK = 2'd1,
        MAT_C  = 2'd2,
        MAT_D  = 2'd3
    } t_matrix;

    typedef enum logic [1:0] {
        REG_CONTROL     = 2'd0,
        REG_MEASUREMENT = 2'd1,
        REG_STATE       = 2'd2,
        REG_OUTPUT      = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_ROUND,
        S_COPY,
        S_ERR
    } t_state;

    typedef enum logic {
        PH_OUT,
        PH_ST
    } t_phase;

    typedef struct packed {
        logic clr;      // zero the accumulator
        logic load;     // take new operands and start
    } t_mac_ctl;

    typedef struct packed {
        logic busy;     // multiplier bits still shifting
    } t_mac_sts;

endpackage

@@ rtl/ssk_if.sv @@
// ----------------------------------------------------------------------------
// ssk_if: request channels of the estimator step
// Input item, result item and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface ssk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [1:0]  matrix_select;
    logic [2:0]  row_index;
    logic [2:0]  column_index;
    logic signed [31:0] value;
    logic        last_element;

    modport source (output valid, opcode, matrix_select, row_index, column_index,
                    value, last_element, input ready);
    modport sink   (input valid, opcode, matrix_select, row_index, column_index,
                    value, last_element, output ready);
endinterface

interface ssk_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] estimate;
    logic [2:0]  output_index;
    logic        last_output;
    logic        ok;

    modport source (output valid, estimate, output_index, last_output, ok,
                    input ready);
    modport sink   (input valid, estimate, output_index, last_output, ok,
                    output ready);
endinterface

interface ssk_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [3:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ssk_mac.sv @@
// ----------------------------------------------------------------------------
// ssk_mac: bit-serial multiply-accumulate
// Multiplier shifts out one bit per cycle, LSB first; the sign bit subtracts.
// ----------------------------------------------------------------------------
module ssk_mac
    import ssk_pkg::*;
#(
    parameter int MC_W  = 32,
    parameter int MP_W  = 32,
    parameter int ACC_W = 70
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [MC_W-1:0]  i_mcand,
    input  logic signed [MP_W-1:0]  i_mplier,
    output t_mac_sts                o_sts,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam int CW = $clog2(MP_W + 1);

    logic [CW-1:0]          r_cnt, n_cnt;
    logic signed [ACC_W-1:0] r_mc, n_mc;
    logic [MP_W-1:0]        r_mp, n_mp;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    always_comb begin
        n_cnt = r_cnt;
        n_mc  = r_mc;
        n_mp  = r_mp;
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end
        if (i_ctl.load) begin
            n_mc  = ACC_W'(i_mcand);
            n_mp  = i_mplier;
            n_cnt = CW'(MP_W);
        end else if (r_cnt != '0) begin
            if (r_mp[0]) begin
                // top bit of a two's complement multiplier weighs negative
                n_acc = (r_cnt == CW'(1)) ? r_acc - r_mc : r_acc + r_mc;
            end
            n_mc  = r_mc <<< 1;
            n_mp  = r_mp >> 1;
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_mc  <= n_mc;
        r_mp  <= n_mp;
        r_acc <= n_acc;
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_acc      = r_acc;

endmodule

@@ rtl/steady_state_kalman_step.sv @@
// ----------------------------------------------------------------------------
// steady_state_kalman_step: steady-state estimator step, bit-serial MAC
// Coefficient and initial-state requests load the store and prior state;
// sample requests fill u and the last one runs y = Cx + Du, x = Ax + (B+K)u.
// ----------------------------------------------------------------------------
// Use:
//   i_in   : input requests (load coefficient, sample element, initial state).
//            Ready is high whenever no step is running.
//   o_out  : estimates, one request per output element, last_output on the
//            final one. Oversized u gives one request with ok low, estimate 0.
//   i_cfg  : register writes, always ready; write only while idle.
// Sequence: every product runs through one shared bit-serial multiplier: a memory
//   read, an operand load, a shift through all VALUE_WIDTH multiplier bits and a
//   check that the multiplier is done; each row then ends with a rounding step.
// Reset: counts return to 2/2/4/4, prior state and u clear to zero; the
//   coefficient store is undefined until written.
// Stall: an estimate waits in the output register; the sequencer holds at
//   the rounding stage until the register is free, so nothing is lost.
// ----------------------------------------------------------------------------
module steady_state_kalman_step
    import ssk_pkg::*;
#(
    parameter int MAX_DIM     = 8,
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssk_in_if.sink     i_in,
    ssk_out_if.source  o_out,
    ssk_cfg_if.sink    i_cfg
);

    localparam int VW    = VALUE_WIDTH;
    localparam int IW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int ACC_W = IW + VW + 6;     // 16 products plus rounding headroom
    localparam int MEM_D = 4 * DIM * DIM;
    localparam int AW    = $clog2(MEM_D);

    // configuration
    logic [3:0] r_cc, r_mc, r_sc, r_oc;

    // stores
    logic signed [IW-1:0] r_mem [MEM_D];
    logic signed [IW-1:0] r_coef;
    logic signed [VW-1:0] r_x    [DIM];
    logic signed [VW-1:0] r_u    [DIM];
    logic signed [VW-1:0] r_next [DIM];

    // sequencer
    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [2:0] r_i, n_i;
    logic [4:0] r_j, n_j;
    logic [3:0] r_ns, r_no;
    logic [4:0] r_terms;

    // output register
    logic                 r_ovld;
    logic signed [31:0]   r_est;
    logic [2:0]           r_oidx;
    logic                 r_olast, r_ook;

    t_mac_ctl               mac_ctl;
    t_mac_sts               mac_sts;
    logic signed [ACC_W-1:0] mac_acc;

    // per-term operand selection
    logic                 term_is_x;
    logic [4:0]           col_w;
    logic [2:0]           col;
    t_matrix              sel;
    logic [AW-1:0]        rd_addr;
    logic signed [VW-1:0] vec;

    // step set-up from the live counts
    logic [4:0] total;
    logic [3:0] ns_c, no_c, ncol_c;
    logic       in_acc, out_acc, start;

    // rounding
    logic signed [ACC_W-1:0] rnd;
    logic [ACC_W-IW:0]       hi_iw;
    logic [ACC_W-VW:0]       hi_vw;
    logic signed [IW-1:0]    sat_iw;
    logic signed [VW-1:0]    sat_vw;

    ssk_mac #(
        .MC_W  (IW),
        .MP_W  (VW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_mcand  (r_coef),
        .i_mplier (vec),
        .o_sts    (mac_sts),
        .o_acc    (mac_acc)
    );

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign start   = in_acc && (i_in.opcode == OP_SAMPLE) && i_in.last_element;

    assign total  = {1'b0, r_cc} + {1'b0, r_mc};
    assign ns_c   = (r_sc == 4'd0) ? 4'd1 : ((r_sc > 4'(DIM)) ? 4'(DIM) : r_sc);
    assign no_c   = (r_oc == 4'd0) ? 4'd1 : ((r_oc > 4'(DIM)) ? 4'(DIM) : r_oc);
    assign ncol_c = (total > 5'(DIM)) ? 4'(DIM) : total[3:0];

    // terms: state columns first, then the combined input vector
    assign term_is_x = (r_j < {1'b0, r_ns});
    assign col_w     = term_is_x ? r_j : (r_j - {1'b0, r_ns});
    assign col       = col_w[2:0];
    always_comb begin
        if (r_phase == PH_OUT) begin
            sel = term_is_x ? MAT_C : MAT_D;
        end else begin
            sel = term_is_x ? MAT_A : MAT_BK;
        end
    end
    assign rd_addr = {sel, r_i, col};
    assign vec     = term_is_x ? r_x[col] : r_u[col];

    // round half up at FRAC_BITS, then saturate
    assign rnd    = (mac_acc + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign hi_iw  = rnd[ACC_W-1:IW-1];
    assign hi_vw  = rnd[ACC_W-1:VW-1];
    assign sat_iw = ((&hi_iw) || !(|hi_iw)) ? rnd[IW-1:0]
                  : (rnd[ACC_W-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}});
    assign sat_vw = ((&hi_vw) || !(|hi_vw)) ? rnd[VW-1:0]
                  : (rnd[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_i         = r_i;
        n_j         = r_j;
        mac_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (total > 5'(MAX_DIM)) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_FETCH;
                        n_phase = PH_OUT;
                        n_i     = '0;
                        n_j     = '0;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                mac_ctl.load = 1'b1;
                mac_ctl.clr  = (r_j == '0);
                n_state      = S_MUL;
            end
            S_MUL: begin
                if (!mac_sts.busy) begin
                    if (r_j == r_terms - 5'd1) begin
                        n_state = S_ROUND;
                    end else begin
                        n_j     = r_j + 5'd1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_ROUND: begin
                if (r_phase == PH_OUT) begin
                    if (!r_ovld) begin
                        n_j     = '0;
                        n_state = S_FETCH;
                        if ({1'b0, r_i} == r_no - 4'd1) begin
                            n_phase = PH_ST;
                            n_i     = '0;
                        end else begin
                            n_i = r_i + 3'd1;
                        end
                    end
                end else begin
                    n_j = '0;
                    if ({1'b0, r_i} == r_ns - 4'd1) begin
                        n_state = S_COPY;
                    end else begin
                        n_i     = r_i + 3'd1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_COPY: begin
                n_state = S_IDLE;
            end
            S_ERR: begin
                if (!r_ovld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_OUT;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // step dimensions are latched at the trigger
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_ns    <= ns_c;
            r_no    <= no_c;
            r_terms <= {1'b0, ns_c} + {1'b0, ncol_c};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= 4'd2;
            r_mc <= 4'd2;
            r_sc <= 4'd4;
            r_oc <= 4'd4;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CONTROL:     r_cc <= i_cfg.data;
                REG_MEASUREMENT: r_mc <= i_cfg.data;
                REG_STATE:       r_sc <= i_cfg.data;
                REG_OUTPUT:      r_oc <= i_cfg.data;
                default:         r_cc <= r_cc;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // coefficient memory: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.opcode == OP_COEF) begin
            r_mem[{i_in.matrix_select, i_in.row_index, i_in.column_index}] <=
                i_in.value[IW-1:0];
        end
        r_coef <= r_mem[rd_addr];
    end

    // prior state, input vector, next-state buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIM; k++) begin
                r_x[k] <= '0;
                r_u[k] <= '0;
            end
        end else begin
            if (in_acc && i_in.opcode == OP_STATE) begin
                r_x[i_in.row_index] <= VW'($signed(i_in.value[IW-1:0]));
            end
            if (in_acc && i_in.opcode == OP_SAMPLE) begin
                r_u[i_in.column_index] <= VW'($signed(i_in.value[IW-1:0]));
            end
            if (r_state == S_COPY) begin
                for (int k = 0; k < DIM; k++) begin
                    if (k < int'(r_ns)) begin
                        r_x[k] <= r_next[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND && r_phase == PH_ST) begin
            r_next[r_i] <= sat_vw;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (!r_ovld && ((r_state == S_ROUND && r_phase == PH_OUT)
                                 || r_state == S_ERR)) begin
            r_ovld <= 1'b1;
        end else if (out_acc) begin
            r_ovld <= 1'b0;
        end
        if (!r_ovld) begin
            if (r_state == S_ROUND && r_phase == PH_OUT) begin
                r_est   <= 32'(sat_iw);
                r_oidx  <= r_i;
                r_olast <= ({1'b0, r_i} == r_no - 4'd1);
                r_ook   <= 1'b1;
            end else if (r_state == S_ERR) begin
                r_est   <= '0;
                r_oidx  <= '0;
                r_olast <= 1'b1;
                r_ook   <= 1'b0;
            end
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovld;
    assign o_out.estimate      = r_est;
    assign o_out.output_index  = r_oidx;
    assign o_out.last_output   = r_olast;
    assign o_out.ok            = r_ook;

`ifndef SYNTHESIS
    a_mac_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_sts.busy |-> (r_state == S_MUL))
        else $error("multiplier busy outside multiply state");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !mac_sts.busy)
        else $error("input ready while multiplier busy");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_phase == PH_ST) |-> ({1'b0, r_i} < r_ns))
        else $error("state row beyond state count");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for steady_state_kalman_step
// Loads the whole coefficient store, then runs phases of register settings
// (reset counts, extremes, clamped and oversized counts) with directed and
// random requests under varying sender idling and receiver stalls. A class
// models the store, prior state and u and checks every estimate in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ssk_pkg::*;

    localparam int      HALF_PERIOD = 4;
    localparam int      CYCLE_LIMIT = 3000000;
    localparam int      DRAIN_WAIT  = 9000;    // covers the longest step

    typedef struct {
        t_opcode            op;
        t_matrix            sel;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] val;
        logic               last;
    } t_req;

    typedef struct {
        logic signed [31:0] estimate;
        logic [2:0]         index;
        logic               last;
        logic               ok;
    } t_est;

    // ------------------------------------------------------------------------
    // Estimator model and in-order checker
    // ------------------------------------------------------------------------
    class est_scoreboard;
        logic signed [31:0] coef [4][8][8];
        logic signed [31:0] x_prior [8];
        logic signed [31:0] u_vec [8];
        logic [3:0]         counts [4];
        t_est               est_q [$];
        int                 mismatches;

        function new();
            foreach (x_prior[i]) begin
                x_prior[i] = '0;
                u_vec[i]   = '0;
            end
            counts[REG_CONTROL]     = 4'd2;
            counts[REG_MEASUREMENT] = 4'd2;
            counts[REG_STATE]       = 4'd4;
            counts[REG_OUTPUT]      = 4'd4;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [3:0] data);
            counts[idx] = data;
        endfunction

        function int pending();
            return est_q.size();
        endfunction

        static function logic signed [31:0] round_sat(logic signed [127:0] acc);
            logic signed [127:0] s;
            s = (acc + 128'sd32768) >>> 16;
            if (s > 128'sd2147483647)
                return 32'sh7fffffff;
            if (s < -128'sd2147483648)
                return 32'sh80000000;
            return s[31:0];
        endfunction

        // sum of coef[sel][row][j] * vec[j] for j < n
        function logic signed [127:0] dot(t_matrix sel, int row,
                                          logic signed [31:0] vec [8], int n);
            logic signed [127:0] acc, a, b;
            acc = '0;
            for (int j = 0; j < n; j++) begin
                a = coef[sel][row][j];
                b = vec[j];
                acc = acc + a * b;
            end
            return acc;
        endfunction

        function void note(t_req r);
            int total, ns, no;
            logic signed [31:0] x_next [8];
            t_est e;
            case (r.op)
                OP_COEF:   coef[r.sel][r.row][r.col] = r.val;
                OP_STATE:  x_prior[r.row] = r.val;
                OP_SAMPLE: begin
                    u_vec[r.col] = r.val;
                    if (r.last) begin
                        total = counts[REG_CONTROL] + counts[REG_MEASUREMENT];
                        if (total > 8) begin
                            // oversized u: single error result, state kept
                            e = '{estimate: '0, index: '0, last: 1'b1, ok: 1'b0};
                            est_q.push_back(e);
                        end else begin
                            ns = counts[REG_STATE];
                            no = counts[REG_OUTPUT];
                            ns = (ns < 1) ? 1 : (ns > 8) ? 8 : ns;
                            no = (no < 1) ? 1 : (no > 8) ? 8 : no;
                            for (int i = 0; i < no; i++) begin
                                e.estimate = round_sat(dot(MAT_C, i, x_prior, ns)
                                                       + dot(MAT_D, i, u_vec, total));
                                e.index = 3'(i);
                                e.last  = (i == no - 1);
                                e.ok    = 1'b1;
                                est_q.push_back(e);
                            end
                            for (int i = 0; i < ns; i++)
                                x_next[i] = round_sat(dot(MAT_A, i, x_prior, ns)
                                                      + dot(MAT_BK, i, u_vec, total));
                            for (int i = 0; i < ns; i++)
                                x_prior[i] = x_next[i];
                        end
                    end
                end
                default: ;  // unused opcode: ignored
            endcase
        endfunction

        function void check(t_est got);
            t_est want;
            if (est_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected estimate %0d idx %0d", got.estimate,
                             got.index);
                return;
            end
            want = est_q.pop_front();
            if (got.estimate !== want.estimate || got.index !== want.index ||
                got.last !== want.last || got.ok !== want.ok) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: est exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.estimate, want.index, want.last, want.ok,
                             got.estimate, got.index, got.last, got.ok);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    ssk_in_if  in_ch ();
    ssk_out_if out_ch ();
    ssk_cfg_if cfg_ch ();

    steady_state_kalman_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    est_scoreboard sb = new();

    int idle_pct  = 0;      // sender idle chance per cycle
    int stall_pct = 0;      // receiver stall chance per cycle
    int hold_cnt  = 0;      // long receiver hold-off, in cycles
    int cycles    = 0;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("steady_state_kalman_step test failed");
            $finish;
        end
    end

    // receiver: ready changes on the falling edge, results taken on the rising
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check('{estimate: out_ch.estimate, index: out_ch.output_index,
                       last: out_ch.last_output, ok: out_ch.ok});
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // mostly small Q16.16 values so sums stay in range; now and then any word
    function automatic logic signed [31:0] rand_val();
        if ($urandom_range(7) == 0)
            return $urandom();
        return $signed($urandom_range(262143)) - 32'sd131072;
    endfunction

    task automatic send(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.opcode        = r.op;
        in_ch.matrix_select = r.sel;
        in_ch.row_index     = r.row;
        in_ch.column_index  = r.col;
        in_ch.value         = r.val;
        in_ch.last_element  = r.last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note(r);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_fields(t_opcode op, t_matrix sel, int row, int col,
                               logic signed [31:0] val, logic last);
        t_req r;
        r = '{op: op, sel: sel, row: 3'(row), col: 3'(col), val: val, last: last};
        send(r);
    endtask

    task automatic write_reg(t_reg_index idx, int data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = 4'(data);
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, 4'(data));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // all results in, then let the state update finish
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one sample: positions 0..n-1 in order, last on the final one
    task automatic send_sample(int n);
        for (int k = 0; k < n; k++)
            send_fields(OP_SAMPLE, MAT_A, $urandom_range(7), k, rand_val(), k == n - 1);
    endtask

    task automatic run_random(int n_items);
        int sent, total, n;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    total = sb.counts[REG_CONTROL] + sb.counts[REG_MEASUREMENT];
                    n = (total > 8) ? $urandom_range(1, 3) : (total == 0) ? 1 : total;
                    send_sample(n);
                    sent += n;
                end
                6, 7: begin
                    send_fields(OP_COEF, t_matrix'($urandom_range(3)), $urandom_range(7),
                                $urandom_range(7), rand_val(), $urandom_range(1));
                    sent++;
                end
                8: begin
                    send_fields(OP_STATE, MAT_A, $urandom_range(7), $urandom_range(7),
                                rand_val(), $urandom_range(1));
                    sent++;
                end
                default: begin
                    // noise: unused opcode, or a stray sample without last
                    if ($urandom_range(1)) begin
                        send_fields(OP_NONE, t_matrix'($urandom_range(3)),
                                    $urandom_range(7), $urandom_range(7), $urandom(), 1'b1);
                    end else begin
                        send_fields(OP_SAMPLE, MAT_A, 0, $urandom_range(7),
                                    rand_val(), 1'b0);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic set_counts(int cc, int mc, int sc, int oc);
        write_reg(REG_CONTROL, cc);
        write_reg(REG_MEASUREMENT, mc);
        write_reg(REG_STATE, sc);
        write_reg(REG_OUTPUT, oc);
    endtask

    task automatic set_mode(int mode);
        case (mode)
            1:       begin idle_pct = 68; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 68; end
            3:       begin idle_pct = 7;  stall_pct = 7;  end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_COEF;
        in_ch.matrix_select = MAT_A;
        in_ch.row_index     = '0;
        in_ch.column_index  = '0;
        in_ch.value         = '0;
        in_ch.last_element  = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_CONTROL;
        cfg_ch.data         = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill the whole store so no unwritten entry is ever read
        for (int m = 0; m < 4; m++)
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++)
                    send_fields(OP_COEF, t_matrix'(m), r, c, rand_val(), 1'b0);

        // directed, at reset counts: extremes of values, saturation both ways
        send_fields(OP_STATE, MAT_A, 0, 0, 32'sh7fffffff, 1'b1);   // stray last
        send_fields(OP_STATE, MAT_A, 1, 0, 32'sh80000000, 1'b0);
        send_fields(OP_STATE, MAT_A, 7, 7, 32'sh00010000, 1'b0);   // unused entry
        send_fields(OP_COEF, MAT_C, 0, 0, 32'sh7fffffff, 1'b1);    // stray last
        send_fields(OP_COEF, MAT_C, 1, 0, 32'sh80000000, 1'b0);
        send_fields(OP_NONE, MAT_D, 7, 7, 32'sh7fffffff, 1'b1);    // ignored
        send_fields(OP_SAMPLE, MAT_A, 0, 7, 32'sh7fffffff, 1'b0);  // unused slot
        send_fields(OP_SAMPLE, MAT_A, 0, 0, 32'sh7fffffff, 1'b0);
        send_fields(OP_SAMPLE, MAT_A, 0, 1, 32'sh80000000, 1'b0);
        send_fields(OP_SAMPLE, MAT_A, 0, 2, 32'sh00000000, 1'b0);
        send_fields(OP_SAMPLE, MAT_A, 0, 3, 32'shffffffff, 1'b1);
        send_fields(OP_COEF, MAT_C, 0, 0, 32'sh00008000, 1'b0);
        send_fields(OP_COEF, MAT_C, 1, 0, 32'shffff8000, 1'b0);
        send_sample(4);
        run_random(6);
        drain();

        // minimum counts, sender idling
        set_mode(1);
        set_counts(0, 0, 1, 1);
        run_random(4);
        drain();

        // largest step, receiver stalling
        set_mode(2);
        set_counts(8, 0, 8, 8);
        run_random(4);
        drain();

        // oversized u (output count also out of range), light idling on both sides
        set_mode(3);
        set_counts(15, 15, 0, 15);
        run_random(4);
        drain();

        // full u split over both parts; pause for every result mid-phase
        set_mode(0);
        set_counts(3, 5, 6, 3);
        run_random(3);
        while (sb.pending() != 0) @(posedge i_clk);
        run_random(3);
        drain();

        // clamped state count and zero output count
        set_mode(2);
        set_counts(1, 2, 15, 0);
        run_random(4);
        drain();

        // one past capacity
        set_mode(1);
        set_counts(5, 4, 2, 2);
        run_random(4);
        drain();

        // long receiver hold-off while requests keep coming
        set_mode(0);
        set_counts(4, 4, 8, 8);
        hold_cnt = 30000;
        send_sample(8);
        run_random(4);
        set_mode(3);
        run_random(4);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("steady_state_kalman_step test passed");
        end else begin
            $display("steady_state_kalman_step test failed");
        end
        $finish;
    end
endmodule
